>>> rtl/automaton_pattern_matcher_unit_defines.svh
// assertion macros for the automaton pattern matcher unit
`ifndef AUTOMATON_PATTERN_MATCHER_UNIT_DEFINES_SVH
`define AUTOMATON_PATTERN_MATCHER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define APM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apm assertion failed");
`define APM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apm assertion failed");
`else
`define APM_ASSERT_IMP(lbl, ante, cons)
`define APM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/apm_pkg.sv
// shared constants, register codes and control types of the pattern matcher
package apm_pkg;

  localparam int MAX_PATTERN_DEF    = 8;
  localparam int ALPHABET_SIZE_DEF  = 256;
  localparam int POSITION_WIDTH_DEF = 32;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int PAT_W       = 64;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 4;
  localparam int START_W     = 32;
  localparam int STATE_OUT_W = 4;

  typedef enum logic {
    REG_PATTERN_LENGTH = 1'b0,
    REG_PATTERN_BYTES  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic accept;
    logic sweep_rd;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic row_last;
  } status_t;

endpackage

>>> rtl/apm_in_if.sv
// text word channel of the pattern matcher
interface apm_in_if import apm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              first_byte;

  modport source (output valid, output text_byte, output first_byte, input ready);
  modport sink (input valid, input text_byte, input first_byte, output ready);
endinterface

>>> rtl/apm_out_if.sv
// result word channel of the pattern matcher
interface apm_out_if import apm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [START_W-1:0]     match_start;
  logic [STATE_OUT_W-1:0] current_state;

  modport source (output valid, output found, output match_start, output current_state,
                  input ready);
  modport sink (input valid, input found, input match_start, input current_state,
                output ready);
endinterface

>>> rtl/apm_ctrl.sv
// controller: table build sweep sequencing and word handshake
`include "automaton_pattern_matcher_unit_defines.svh"

module apm_ctrl import apm_pkg::*; #(
  parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  localparam int SW    = $clog2(MAX_PATTERN + 1),
  localparam int ABITS = $clog2(ALPHABET_SIZE)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  status_t          st,
  output cmd_t             cmd,
  output logic [SW-1:0]    row,
  output logic [ABITS-1:0] col
);

  localparam int CW = ABITS + 1;

  typedef enum logic [1:0] {
    S_BUILD = 2'b01,
    S_RUN   = 2'b10
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] col_cnt;
  logic          col_end;
  logic          accept;

  assign col_end = (col_cnt == CW'(ALPHABET_SIZE));
  assign col     = col_cnt[ABITS-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_BUILD: begin
        if (col_end && st.row_last) state_next = S_RUN;
      end
      S_RUN: state_next = S_RUN;
      default: state_next = S_BUILD;
    endcase
    if (st.cfg_wr) state_next = S_BUILD;
  end

  assign in_ready     = (state == S_RUN) && (!out_valid || out_ready);
  assign accept       = in_valid && in_ready;
  assign cmd.accept   = accept;
  assign cmd.sweep_rd = (state == S_BUILD) && !col_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BUILD;
      row       <= '0;
      col_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (st.cfg_wr) begin
        row     <= '0;
        col_cnt <= '0;
      end else if (state == S_BUILD) begin
        if (col_end) begin
          col_cnt <= '0;
          if (!st.row_last) row <= row + SW'(1);
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `APM_ASSERT_NXT(a_cfg_restarts_build, st.cfg_wr, state == S_BUILD)
  `APM_ASSERT_NXT(a_accept_gives_result, accept, out_valid)
  `APM_ASSERT_NXT(a_build_ends, (state == S_BUILD) && col_end && st.row_last && !st.cfg_wr, state == S_RUN)
  `APM_ASSERT_IMP(a_col_bound, 1'b1, col_cnt <= CW'(ALPHABET_SIZE))

endmodule

>>> rtl/apm_dpath.sv
// datapath: config registers, transition table memory, build and lookup logic
module apm_dpath import apm_pkg::*; #(
  parameter int MAX_PATTERN    = MAX_PATTERN_DEF,
  parameter int ALPHABET_SIZE  = ALPHABET_SIZE_DEF,
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  localparam int SW    = $clog2(MAX_PATTERN + 1),
  localparam int ABITS = $clog2(ALPHABET_SIZE)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  logic [BYTE_W-1:0]      text_byte,
  input  logic                   first_byte,
  output logic                   found,
  output logic [START_W-1:0]     match_start,
  output logic [STATE_OUT_W-1:0] current_state,
  input  cmd_t                   cmd,
  output status_t                st,
  input  logic [SW-1:0]          row,
  input  logic [ABITS-1:0]       col
);

  localparam int NSTATES = MAX_PATTERN + 1;
  localparam int AW      = SW + ABITS;
  localparam int DEPTH   = NSTATES * (1 << ABITS);
  localparam int XW      = BYTE_W + 1;
  localparam int PW      = POSITION_WIDTH;

  logic [LEN_W-1:0]  pattern_length;
  logic [PAT_W-1:0]  pattern_bytes;
  logic              cfg_wr;
  reg_idx_t          reg_idx;
  logic [SW-1:0]     eff_len;

  logic [SW-1:0]     tt_mem [DEPTH];
  logic [SW-1:0]     mem_q;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  logic              wr_pend;
  logic [SW-1:0]     wr_row;
  logic [ABITS-1:0]  wr_col;
  logic [BYTE_W-1:0] wr_pat;
  logic              wr_hit;
  logic [SW-1:0]     wval;
  logic [SW-1:0]     fail;
  logic [SW-1:0]     fcap;

  logic              st_clr;
  logic              oob;
  logic [SW-1:0]     match_state;
  logic [SW-1:0]     st_sel;
  logic [PW-1:0]     text_position;
  logic [PW-1:0]     pos_use;
  logic [PW-1:0]     res_pos;

  // configuration port
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_LENGTH: prdata = DATA_W'(pattern_length);
      REG_PATTERN_BYTES:  prdata = DATA_W'(pattern_bytes);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      pattern_bytes  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PATTERN_LENGTH: pattern_length <= pwdata[LEN_W-1:0];
        REG_PATTERN_BYTES:  pattern_bytes  <= pwdata[PAT_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      eff_len = SW'(1);
    end else if (32'(pattern_length) > 32'(MAX_PATTERN)) begin
      eff_len = SW'(MAX_PATTERN);
    end else begin
      eff_len = SW'(pattern_length);
    end
  end

  assign st.cfg_wr   = cfg_wr;
  assign st.row_last = (row == eff_len);

  // table memory, one read and one write port
  assign match_state = (st_clr || oob) ? '0 : mem_q;
  assign st_sel      = first_byte ? '0 : match_state;
  assign rd_en       = cmd.sweep_rd || cmd.accept;
  assign rd_addr     = cmd.sweep_rd ? {fail, col} : {st_sel, text_byte[ABITS-1:0]};

  always_ff @(posedge clk) begin
    if (wr_pend) tt_mem[{wr_row, wr_col}] <= wval;
    if (rd_en) mem_q <= tt_mem[rd_addr];
  end

  // build: entry is k+1 on a pattern hit, else 0 in row 0 and the entry of the failure row
  assign wr_pat = BYTE_W'(pattern_bytes >> {wr_row, 3'b000});
  assign wr_hit = (wr_row < eff_len) && (BYTE_W'(wr_col) == wr_pat);

  always_comb begin
    if (wr_hit) begin
      wval = wr_row + SW'(1);
    end else if (wr_row == '0) begin
      wval = '0;
    end else begin
      wval = mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.sweep_rd && !cfg_wr;
    end
  end

  always_ff @(posedge clk) begin
    wr_row <= row;
    wr_col <= col;
  end

  // failure row for the next row, taken on the pattern byte of this row
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      fail <= '0;
      fcap <= '0;
    end else if (wr_pend) begin
      if (wr_hit) fcap <= mem_q;
      if (wr_col == ABITS'(ALPHABET_SIZE - 1)) begin
        if (wr_row == '0) begin
          fail <= '0;
        end else if (wr_hit) begin
          fail <= mem_q;
        end else begin
          fail <= fcap;
        end
      end
    end
  end

  // text position and state flags
  assign pos_use = first_byte ? '0 : text_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_position <= '0;
      st_clr        <= 1'b1;
      oob           <= 1'b0;
    end else if (cfg_wr) begin
      st_clr <= 1'b1;
    end else if (cmd.accept) begin
      st_clr <= 1'b0;
      oob    <= ({1'b0, text_byte} >= XW'(ALPHABET_SIZE));
      if (pos_use != {PW{1'b1}}) begin
        text_position <= pos_use + PW'(1);
      end else begin
        text_position <= pos_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) res_pos <= pos_use;
  end

  assign found         = (match_state == eff_len);
  assign current_state = STATE_OUT_W'(match_state);
  assign match_start   = found ? (START_W'(res_pos) + START_W'(1) - START_W'(eff_len)) : '0;

endmodule

>>> rtl/automaton_pattern_matcher_unit.sv
// top level of the automaton pattern matcher unit
// a result word becomes valid in the cycle after its text word is accepted
// throughput: one word per cycle while the result side takes words; each word is
//   one read of the transition table memory, whose registered output is the state
// reset and every config write rebuild the table, rows 0 to L of ALPHABET_SIZE entries,
//   with L the effective pattern length; no text word is taken meanwhile
module automaton_pattern_matcher_unit import apm_pkg::*; #(
  parameter int MAX_PATTERN    = MAX_PATTERN_DEF,
  parameter int ALPHABET_SIZE  = ALPHABET_SIZE_DEF,
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  apm_in_if.sink            text_in,
  apm_out_if.source         result_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int SW    = $clog2(MAX_PATTERN + 1);
  localparam int ABITS = $clog2(ALPHABET_SIZE);

  cmd_t             cmd;
  status_t          st;
  logic [SW-1:0]    row;
  logic [ABITS-1:0] col;

  apm_ctrl #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text_in.valid),
    .in_ready  (text_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .st        (st),
    .cmd       (cmd),
    .row       (row),
    .col       (col)
  );

  apm_dpath #(
    .MAX_PATTERN    (MAX_PATTERN),
    .ALPHABET_SIZE  (ALPHABET_SIZE),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .text_byte     (text_in.text_byte),
    .first_byte    (text_in.first_byte),
    .found         (result_out.found),
    .match_start   (result_out.match_start),
    .current_state (result_out.current_state),
    .cmd           (cmd),
    .st            (st),
    .row           (row),
    .col           (col)
  );

endmodule

>>> sim/automaton_pattern_matcher_unit_test.sv
// self-checking testbench for the automaton pattern matcher unit
module automaton_pattern_matcher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import apm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 12;
  localparam int WORDS_PER_PHASE = 120;
  localparam int STATES = MAX_PATTERN_DEF + 1;

  typedef struct packed {
    logic                   found;
    logic [START_W-1:0]     match_start;
    logic [STATE_OUT_W-1:0] current_state;
  } match_result_t;

  typedef enum logic {
    ROW_WORD,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    reg_idx_t          idx;
    logic [DATA_W-1:0] value;
    logic [BYTE_W-1:0] text_byte;
    logic              first_byte;
    logic              typed;
    match_result_t     want;
  } text_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  apm_in_if text_chan();
  apm_out_if result_chan();

  automaton_pattern_matcher_unit dut (
    .clk(clk),
    .rst(rst),
    .text_in(text_chan.sink),
    .result_out(result_chan.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // matcher model state
  logic [LEN_W-1:0]       pat_len;
  logic [PAT_W-1:0]       pat_bytes;
  logic [LEN_W-1:0]       auto_state;
  logic [START_W-1:0]     text_pos;
  logic [LEN_W-1:0]       next_state_tbl [STATES][ALPHABET_SIZE_DEF];
  match_result_t          predicted_matches [$];

  int error_count = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  text_row_t directed_rows [25] = '{
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b1, 1'b1, '{1'b1, 32'd0, 4'd1}},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b0, 1'b1, '{1'b0, 32'd0, 4'd0}},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b1, '{1'b1, 32'd2, 4'd1}},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b1, '{1'b1, 32'd3, 4'd1}},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h80, 1'b1, 1'b1, '{1'b0, 32'd0, 4'd0}},
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_PATTERN_BYTES, 64'hFF00_FF00_FF00_FF00, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b1, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b0, 1'b1, '{1'b1, 32'd0, 4'd8}},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'h3, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, '0}
  };

  function automatic int eff_len();
    if (pat_len == '0) return 1;
    if (int'(pat_len) > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
    return int'(pat_len);
  endfunction

  function automatic logic [BYTE_W-1:0] pat_byte(input int i);
    return pat_bytes[BYTE_W*i +: BYTE_W];
  endfunction

  // longest pattern prefix that ends the matched prefix of length k followed by x
  function automatic logic [LEN_W-1:0] longest_border(input int m, input int k,
                                                      input logic [BYTE_W-1:0] x);
    bit ok;
    if (k < m && x == pat_byte(k)) return LEN_W'(k + 1);
    for (int n = k; n > 0; n--) begin
      if (pat_byte(n - 1) == x) begin
        ok = 1'b1;
        for (int i = 0; i + 1 < n; i++)
          if (pat_byte(i) != pat_byte(k - n + 1 + i)) ok = 1'b0;
        if (ok) return LEN_W'(n);
      end
    end
    return '0;
  endfunction

  function automatic void rebuild_table();
    int m;
    m = eff_len();
    for (int k = 0; k < STATES; k++)
      for (int x = 0; x < ALPHABET_SIZE_DEF; x++)
        next_state_tbl[k][x] = (k <= m) ? longest_border(m, k, BYTE_W'(x)) : '0;
  endfunction

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  task automatic send_text_word(input logic [BYTE_W-1:0] b, input logic f,
                                input logic typed, input match_result_t typed_want);
    match_result_t r;
    logic [START_W-1:0] pos;
    logic [LEN_W-1:0] st;
    int m;
    @(negedge clk);
    if (!no_idle)
      while ($urandom_range(99) < 6) begin
        text_chan.valid <= 1'b0;
        @(negedge clk);
      end
    text_chan.valid <= 1'b1;
    text_chan.text_byte <= b;
    text_chan.first_byte <= f;
    @(posedge clk);
    while (!text_chan.ready) @(posedge clk);
    m = eff_len();
    if (f) begin
      auto_state = '0;
      text_pos = '0;
    end
    pos = text_pos;
    st = auto_state;
    if (int'(st) > m) st = '0;
    st = next_state_tbl[st][b];
    auto_state = st;
    if (text_pos != '1) text_pos = text_pos + 1'b1;
    r.found = (int'(st) == m);
    r.match_start = r.found ? pos + 1'b1 - START_W'(m) : '0;
    r.current_state = st;
    predicted_matches.push_back(typed ? typed_want : r);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] held;
    @(negedge clk);
    text_chan.valid <= 1'b0;
    while (predicted_matches.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 3;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_PATTERN_LENGTH) begin
      pat_len = value[LEN_W-1:0];
      held = DATA_W'(pat_len);
    end else begin
      pat_bytes = value;
      held = value;
    end
    auto_state = '0;
    rebuild_table();
    // read back
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== held)
      flag_error($sformatf("register %s read back %h, expected %h", idx.name(), prdata, held));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    result_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      result_chan.ready <= no_idle || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    match_result_t got;
    match_result_t want;
    if (!rst && result_chan.valid && result_chan.ready) begin
      got.found = result_chan.found;
      got.match_start = result_chan.match_start;
      got.current_state = result_chan.current_state;
      if (predicted_matches.size() == 0) begin
        flag_error($sformatf("unexpected word: found %0b start %0d state %0d",
                             got.found, got.match_start, got.current_state));
      end else begin
        want = predicted_matches.pop_front();
        if (got.found !== want.found || got.match_start !== want.match_start ||
            got.current_state !== want.current_state)
          flag_error($sformatf("mismatch: found %0b/%0b start %0d/%0d state %0d/%0d",
                               want.found, got.found, want.match_start, got.match_start,
                               want.current_state, got.current_state));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("automaton_pattern_matcher_unit_test failed");
      $finish;
    end
  end

  initial begin
    int m;
    int k;
    int roll;
    int sent;
    logic fb;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [PAT_W-1:0] pat;
    logic [LEN_W-1:0] len;

    text_chan.valid <= 1'b0;
    text_chan.text_byte <= '0;
    text_chan.first_byte <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    pat_len = LEN_W'(1);
    pat_bytes = '0;
    auto_state = '0;
    text_pos = '0;
    rebuild_table();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE)
        write_register(directed_rows[i].idx, directed_rows[i].value);
      else
        send_text_word(directed_rows[i].text_byte, directed_rows[i].first_byte,
                       directed_rows[i].typed, directed_rows[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      no_idle = (phase == 8 || phase == 9);
      case (phase)
        0: len = LEN_W'(8);
        1: len = LEN_W'(1);
        2: len = '0;
        3: len = '1;
        default: len = LEN_W'($urandom_range(15));
      endcase
      a = BYTE_W'($urandom_range(255));
      b = ($urandom_range(3) == 0) ? a : BYTE_W'($urandom_range(255));
      for (int i = 0; i < PAT_W / BYTE_W; i++)
        pat[BYTE_W*i +: BYTE_W] = $urandom_range(1) ? a : b;
      if (phase == 4) pat = '1;
      if (phase == 5) pat = '0;
      if (phase == 6 || phase == 7) pat = {$urandom, $urandom};
      if (phase != 11) write_register(REG_PATTERN_BYTES, pat);
      if (phase != 10)
        write_register(REG_PATTERN_LENGTH, {(DATA_W - LEN_W)'($urandom), len});
      m = eff_len();
      fb = 1'($urandom_range(1));
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 25) begin
          k = ($urandom_range(3) == 0) ? $urandom_range(m, 1) : m;
          for (int j = 0; j < k; j++) begin
            send_text_word(pat_byte(j), fb, 1'b0, '0);
            fb = ($urandom_range(99) < 2);
            sent++;
          end
        end else begin
          if (roll < 85) send_text_word(pat_byte($urandom_range(m - 1)), fb, 1'b0, '0);
          else send_text_word(BYTE_W'($urandom_range(255)), fb, 1'b0, '0);
          fb = ($urandom_range(99) < 2);
          sent++;
        end
      end
    end
    no_idle = 1'b0;

    @(negedge clk);
    text_chan.valid <= 1'b0;
    while (predicted_matches.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("automaton_pattern_matcher_unit_test passed");
    else
      $display("automaton_pattern_matcher_unit_test failed");
    $finish;
  end
endmodule

>>> automaton_pattern_matcher_unit.f
+incdir+rtl
rtl/apm_pkg.sv
rtl/apm_in_if.sv
rtl/apm_out_if.sv
rtl/apm_ctrl.sv
rtl/apm_dpath.sv
rtl/automaton_pattern_matcher_unit.sv
sim/automaton_pattern_matcher_unit_test.sv
